// ===== design/rthb_pkg.sv =====
package rthb_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned ACC_W    = 2 * PIX_W;
  localparam int unsigned DIV_STEPS = PIX_W;

  localparam logic [PIX_W-1:0] HUE_SCALE     = 8'd43;
  localparam logic [PIX_W-1:0] HUE_OFS_RED   = 8'd0;
  localparam logic [PIX_W-1:0] HUE_OFS_GREEN = 8'd85;
  localparam logic [PIX_W-1:0] HUE_OFS_BLUE  = 8'd171;

  // Beat carried down the divider chain. Each accumulator holds the partial
  // remainder in its upper half and numerator bits, then quotient bits, below.
  typedef struct packed {
    logic             gray;
    logic             neg;
    logic [PIX_W-1:0] offset;
    logic [PIX_W-1:0] value;
    logic [PIX_W-1:0] sat_den;
    logic [PIX_W-1:0] hue_den;
    logic [ACC_W-1:0] sat_acc;
    logic [ACC_W-1:0] hue_acc;
  } rthb_beat_t;

  // One restoring division step: shift in the next numerator bit, subtract
  // the divisor if it fits, shift in the quotient bit.
  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                               input logic [PIX_W-1:0] den);
    logic [PIX_W:0] trial;
    logic [PIX_W:0] diff;
    logic           fits;
    trial = acc[ACC_W-1:PIX_W-1];
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
    if (fits) begin
      div_step = {diff[PIX_W-1:0], acc[PIX_W-2:0], 1'b1};
    end else begin
      div_step = {trial[PIX_W-1:0], acc[PIX_W-2:0], 1'b0};
    end
  endfunction

endpackage

// ===== design/rgb_to_hsv_byte.sv =====
// Channel  Handshake           Payload
// -------  ------------------  ------------------------------
// input    in_valid/in_ready   red, green, blue (8b unsigned)
// output   out_valid/out_ready hue, saturation, brightness (8b)
//
// Takes one pixel per clock while the output does not stall; each pixel
// passes a register for max/min and numerators, eight divider cells (one
// quotient bit each, saturation and hue side by side) and the output reg.
// Reset (rst, synchronous) empties every stage; no other state is kept.
// A stall at the output fills empty stages first, so ready drops only
// once all ten stages hold a beat.
module rgb_to_hsv_byte import rthb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] hue,
  output logic [PIX_W-1:0] saturation,
  output logic [PIX_W-1:0] brightness
);

  // Link k feeds cell k; link DIV_STEPS feeds the output stage.
  logic       link_valid [DIV_STEPS+1];
  logic       link_ready [DIV_STEPS+1];
  rthb_beat_t link_beat  [DIV_STEPS+1];

  // Find extremes, pick the hue sector, form both numerators.
  rthb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_beat  (link_beat[0])
  );

  // Row of restoring-division cells, one quotient bit per cell.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    rthb_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_beat   (link_beat[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_beat  (link_beat[k+1])
    );
  end

  // Apply hue sign and offset, zero hue and saturation of gray pixels, hold the result.
  rthb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (link_valid[DIV_STEPS]),
    .in_ready   (link_ready[DIV_STEPS]),
    .in_beat    (link_beat[DIV_STEPS]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule

// ===== design/rthb_front.sv =====
module rthb_front import rthb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  output logic             out_valid,
  input  logic             out_ready,
  output rthb_beat_t       out_beat
);

  logic [PIX_W-1:0] mx;
  logic [PIX_W-1:0] mn;
  logic [PIX_W-1:0] chroma;
  logic [PIX_W:0]   sdiff;
  logic [PIX_W-1:0] mag;
  logic [PIX_W-1:0] offset;
  logic [ACC_W-1:0] hue_num;
  logic [ACC_W-1:0] sat_num;
  rthb_beat_t       beat_next;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    chroma = mx - mn;
    // Red wins ties over green, green over blue.
    if (mx == red) begin
      offset = HUE_OFS_RED;
      sdiff  = {1'b0, green} - {1'b0, blue};
    end else if (mx == green) begin
      offset = HUE_OFS_GREEN;
      sdiff  = {1'b0, blue} - {1'b0, red};
    end else begin
      offset = HUE_OFS_BLUE;
      sdiff  = {1'b0, red} - {1'b0, green};
    end
    mag     = sdiff[PIX_W] ? PIX_W'(-sdiff) : sdiff[PIX_W-1:0];
    hue_num = ACC_W'(mag) * ACC_W'(HUE_SCALE);
    sat_num = {chroma, {PIX_W{1'b0}}} - ACC_W'(chroma);

    beat_next.gray    = (chroma == '0);
    beat_next.neg     = sdiff[PIX_W];
    beat_next.offset  = offset;
    beat_next.value   = mx;
    beat_next.sat_den = mx;
    beat_next.hue_den = chroma;
    beat_next.sat_acc = sat_num;
    beat_next.hue_acc = hue_num;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

// ===== design/rthb_div_cell.sv =====
module rthb_div_cell import rthb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rthb_beat_t in_beat,
  output logic       out_valid,
  input  logic       out_ready,
  output rthb_beat_t out_beat
);

  rthb_beat_t beat_next;

  // Advance both quotients by one bit; sideband rides along.
  always_comb begin
    beat_next         = in_beat;
    beat_next.sat_acc = div_step(in_beat.sat_acc, in_beat.sat_den);
    beat_next.hue_acc = div_step(in_beat.hue_acc, in_beat.hue_den);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

// ===== design/rthb_back.sv =====
module rthb_back import rthb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rthb_beat_t       in_beat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] hue,
  output logic [PIX_W-1:0] saturation,
  output logic [PIX_W-1:0] brightness
);

  logic [PIX_W-1:0] q_hue;
  logic [PIX_W-1:0] hue_next;
  logic [PIX_W-1:0] sat_next;

  always_comb begin
    q_hue = in_beat.hue_acc[PIX_W-1:0];
    if (in_beat.gray) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      hue_next = in_beat.neg ? in_beat.offset - q_hue : in_beat.offset + q_hue;
      sat_next = in_beat.sat_acc[PIX_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue        <= hue_next;
      saturation <= sat_next;
      brightness <= in_beat.value;
    end
  end

endmodule

// ===== design/rthb_checker.sv =====
module rthb_checker import rthb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] hue,
  input logic [PIX_W-1:0] saturation,
  input logic [PIX_W-1:0] brightness
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
      && $stable(brightness))
    else $error("stalled result changed");

  a_room : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  a_black : assert property (@(posedge clk) disable iff (rst)
    out_valid && brightness == '0 |-> hue == '0 && saturation == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_gray : assert property (@(posedge clk) disable iff (rst)
    out_valid && saturation == '0 |-> hue == '0)
    else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_byte rthb_checker u_rthb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hue        (hue),
  .saturation (saturation),
  .brightness (brightness)
);
